// ===== sv/rlfpg_pkg.sv =====
// shared types, pattern codes and constant tables for the rgb led pattern generator
// used by every module of the block; depends on nothing else
`default_nettype none

package rlfpg_pkg;

  localparam int TIME_BITS   = 48;
  localparam int PERIOD_BITS = 32;

  localparam int CODE_W  = 4;
  localparam int MOD_W   = 14;
  localparam int PCT_W   = 7;
  localparam int NB      = (TIME_BITS + 7) / 8;
  localparam int EL_PAD  = NB * 8;
  localparam int PROD_W  = 8 + MOD_W;
  localparam int Y_W     = $clog2(NB * 255 * 10000);
  localparam int RECIP_SHIFT = 40;
  localparam int Q_W     = Y_W + 32 - RECIP_SHIFT;
  localparam int REM_W   = MOD_W + 1;
  localparam int Q100_W  = PERIOD_BITS - 6;
  localparam int R100_W  = 7;
  localparam int IN_W    = ((CODE_W + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_W   = 96;

  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [TIME_BITS-1:0]   ms_t;
  typedef logic [MOD_W-1:0]       mod_t;
  typedef logic [PROD_W-1:0]      prod_t;
  typedef logic [Y_W-1:0]         y_t;
  typedef logic [Q_W-1:0]         q_t;
  typedef logic [REM_W-1:0]       rem_t;
  typedef logic [PCT_W-1:0]       pct_t;
  typedef logic [PERIOD_BITS-1:0] per_t;
  typedef logic [Q100_W-1:0]      q100_t;
  typedef logic [R100_W-1:0]      r100_t;

  // pattern codes
  localparam code_t PAT_NONE     = 4'd0;
  localparam code_t PAT_PRIV_REC = 4'd1;
  localparam code_t PAT_PRIV_UNK = 4'd2;
  localparam code_t PAT_VOICE    = 4'd3;
  localparam code_t PAT_BOOT     = 4'd4;
  localparam code_t PAT_PAIR     = 4'd5;
  localparam code_t PAT_UPDATE   = 4'd6;
  localparam code_t PAT_VALIDATE = 4'd7;
  localparam code_t PAT_RECOVERY = 4'd8;
  localparam code_t PAT_FAULT    = 4'd9;
  localparam code_t PAT_CHARGE   = 4'd10;
  localparam code_t PAT_LOWPOW   = 4'd11;
  localparam code_t PAT_READY    = 4'd12;
  localparam code_t PAT_DISCONN  = 4'd13;
  localparam code_t PAT_COUNT    = 4'd14;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  localparam logic [1:0] CFG_RED   = 2'd0;
  localparam logic [1:0] CFG_GREEN = 2'd1;
  localparam logic [1:0] CFG_BLUE  = 2'd2;

  localparam pct_t PCT_FULL  = 7'd100;
  localparam pct_t PCT_AMBER = 7'd30;
  localparam pct_t PCT_VOICE = 7'd50;
  localparam pct_t PCT_OFF   = 7'd0;

  localparam ms_t EL_SHORT = ms_t'(300);

  // floor(x / 100) for 32-bit x: (x * MAGIC100) >> 37
  localparam logic [31:0] MAGIC100 = 32'h51EB851F;
  localparam int MAGIC100_SHIFT = 37;
  // floor(x / 100) for x below 43690: (x * 5243) >> 19
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int DIV100_SHIFT = 19;
  // floor(x / 10) for x below 16384: (x * 6554) >> 16
  localparam logic [12:0] DIV10_MUL = 13'd6554;
  localparam int DIV10_SHIFT = 16;

  typedef struct packed {
    code_t code;
    logic  inv;
    ms_t   el;
  } fe_t;

  typedef struct packed {
    q100_t q;
    r100_t r;
  } chan_scale_t;

  typedef chan_scale_t [2:0] scale_vec_t;

  // cycle length of each pattern; codes without a cycle take a harmless one
  function automatic mod_t pat_modulus(code_t c);
    mod_t m;
    unique case (c)
      PAT_BOOT:     m = mod_t'(2400);
      PAT_UPDATE:   m = mod_t'(2000);
      PAT_VALIDATE: m = mod_t'(1800);
      PAT_RECOVERY: m = mod_t'(3000);
      PAT_FAULT:    m = mod_t'(2450);
      PAT_CHARGE:   m = mod_t'(4000);
      PAT_LOWPOW:   m = mod_t'(10000);
      default:      m = mod_t'(500);
    endcase
    return m;
  endfunction

  // floor(2^40 / modulus)
  function automatic logic [31:0] pat_recip(code_t c);
    logic [31:0] r;
    unique case (c)
      PAT_BOOT:     r = 32'd458129844;
      PAT_UPDATE:   r = 32'd549755813;
      PAT_VALIDATE: r = 32'd610839793;
      PAT_RECOVERY: r = 32'd366503875;
      PAT_FAULT:    r = 32'd448780256;
      PAT_CHARGE:   r = 32'd274877906;
      PAT_LOWPOW:   r = 32'd109951162;
      default:      r = 32'd2199023255;
    endcase
    return r;
  endfunction

  typedef logic [NB-1:0][MOD_W-1:0] res_row_t;
  typedef res_row_t [15:0] res_tab_t;

  // 2^(8*i) mod modulus for every code and byte position
  function automatic res_tab_t build_res_tab();
    res_tab_t tab;
    int unsigned m;
    int unsigned r;
    tab = '0;
    for (int c = 0; c < 16; c++) begin
      m = int'(pat_modulus(code_t'(c)));
      r = 1;
      for (int i = 0; i < NB; i++) begin
        tab[c][i] = mod_t'(r);
        for (int k = 0; k < 8; k++) begin
          r = r * 2;
          if (r >= m) r = r - m;
        end
      end
    end
    return tab;
  endfunction

  localparam res_tab_t RES_TAB = build_res_tab();

endpackage

`default_nettype wire

// ===== sv/rgb_led_feedback_pattern_generator_top.sv =====
// rgb led feedback pattern generator: throughput one transaction per cycle while the
// result side keeps up (a stalled result holds the queue and input), set by the
// back-end pipeline (byte residue fold, reciprocal multiply, decode, scaling) behind a
// two-entry queue. synchronous active-low reset clears the pattern to none, start time
// and periods to zero and empties queue and pipeline; no clearing pass is needed.
// depends on rlfpg_pkg, rlfpg_cfg, rlfpg_front, rlfpg_fifo and rlfpg_back
`default_nettype none

module rgb_led_feedback_pattern_generator_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // pattern_code [3:0], now_ms [51:4], zero pad
  input  wire logic [rlfpg_pkg::IN_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // red_pulse [31:0], green_pulse [63:32], blue_pulse [95:64]
  output logic [rlfpg_pkg::OUT_W-1:0]      out_tdata,
  // status [0]
  output logic                             out_tuser,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_wdata
);

  rlfpg_pkg::scale_vec_t scale;
  rlfpg_pkg::fe_t        push_data;
  rlfpg_pkg::fe_t        rd_data;
  logic push, pop, q_full, q_empty;

  rlfpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .scale     (scale)
  );

  rlfpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rlfpg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rlfpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_data    (rd_data),
    .q_empty    (q_empty),
    .pop        (pop),
    .scale      (scale),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== sv/rlfpg_cfg.sv =====
// period registers and their precomputed split into quotient and remainder by 100
// depends on rlfpg_pkg
`default_nettype none

module rlfpg_cfg (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [31:0]            cfg_wdata,
  output rlfpg_pkg::scale_vec_t       scale
);

  rlfpg_pkg::per_t  period_r [3];
  rlfpg_pkg::q100_t q100_r   [3];
  rlfpg_pkg::r100_t r100_r   [3];
  logic [rlfpg_pkg::PERIOD_BITS+31:0] mul [3];
  rlfpg_pkg::per_t  back     [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) period_r[c] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlfpg_pkg::CFG_RED:   period_r[0] <= rlfpg_pkg::per_t'(cfg_wdata);
        rlfpg_pkg::CFG_GREEN: period_r[1] <= rlfpg_pkg::per_t'(cfg_wdata);
        rlfpg_pkg::CFG_BLUE:  period_r[2] <= rlfpg_pkg::per_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // quotient registered from the period, then remainder registered from the period and that quotient
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mul[c]  = period_r[c] * rlfpg_pkg::MAGIC100;
      back[c] = rlfpg_pkg::per_t'(q100_r[c]) * rlfpg_pkg::per_t'(7'd100);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      q100_r[c] <= rlfpg_pkg::q100_t'(mul[c] >> rlfpg_pkg::MAGIC100_SHIFT);
      r100_r[c] <= rlfpg_pkg::r100_t'(period_r[c] - back[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scale[c].q = q100_r[c];
      scale[c].r = r100_r[c];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rlfpg_front.sv =====
// front end: accepts updates, tracks current pattern and start time, computes elapsed time
// depends on rlfpg_pkg; feeds rlfpg_fifo
`default_nettype none

module rlfpg_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [rlfpg_pkg::IN_W-1:0] in_tdata,
  input  wire logic                  q_full,
  output logic                       push,
  output rlfpg_pkg::fe_t             push_data
);

  rlfpg_pkg::code_t cur_r, cur_nxt;
  rlfpg_pkg::ms_t   start_r, start_nxt;
  rlfpg_pkg::code_t code;
  rlfpg_pkg::ms_t   now;
  logic             inv;
  logic             change;

  assign code      = in_tdata[rlfpg_pkg::CODE_W-1:0];
  assign now       = in_tdata[rlfpg_pkg::CODE_W +: rlfpg_pkg::TIME_BITS];
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign inv       = (code >= rlfpg_pkg::PAT_COUNT);
  assign change    = !inv && (code != cur_r);

  always_comb begin
    cur_nxt   = cur_r;
    start_nxt = start_r;
    if (push && change) begin
      cur_nxt   = code;
      start_nxt = now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= rlfpg_pkg::PAT_NONE;
      start_r <= '0;
    end else begin
      cur_r   <= cur_nxt;
      start_r <= start_nxt;
    end
  end

  // a fresh pattern starts at zero, and time running backwards clamps to zero
  always_comb begin
    push_data.code = code;
    push_data.inv  = inv;
    if (change || now < start_r) push_data.el = '0;
    else push_data.el = now - start_r;
  end

  a_inv_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    push && inv |=> $stable(cur_r) && $stable(start_r))
    else $error("invalid code changed pattern state");

  a_valid_sets_code: assert property (@(posedge clk) disable iff (!rst_n)
    push && !inv |=> cur_r == $past(code))
    else $error("current pattern does not follow accepted code");

endmodule

`default_nettype wire

// ===== sv/rlfpg_fifo.sv =====
// two-entry queue between front end and back end
// depends on rlfpg_pkg
`default_nettype none

module rlfpg_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rlfpg_pkg::fe_t push_data,
  input  wire logic           pop,
  output rlfpg_pkg::fe_t      rd_data,
  output logic                full,
  output logic                empty
);

  rlfpg_pkg::fe_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== sv/rlfpg_back.sv =====
// back end: cycle position by residue folding and reciprocal, pattern decode, pwm scaling
// depends on rlfpg_pkg; drains rlfpg_fifo and drives the result channel
`default_nettype none

module rlfpg_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rlfpg_pkg::fe_t         rd_data,
  input  wire logic                   q_empty,
  output logic                        pop,
  input  wire rlfpg_pkg::scale_vec_t  scale,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [rlfpg_pkg::OUT_W-1:0] out_tdata,
  output logic                        out_tuser
);

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;

  // stage 1: byte residues
  rlfpg_pkg::code_t code1_r;
  logic             inv1_r, lt1_r;
  rlfpg_pkg::prod_t prod1_r [rlfpg_pkg::NB];
  logic [rlfpg_pkg::EL_PAD-1:0] el_pad;
  // stage 2: folded value
  rlfpg_pkg::code_t code2_r;
  logic             inv2_r, lt2_r;
  rlfpg_pkg::y_t    y2_r, ysum;
  // stage 3: quotient estimate
  rlfpg_pkg::code_t code3_r;
  logic             inv3_r, lt3_r;
  rlfpg_pkg::y_t    y3_r;
  rlfpg_pkg::q_t    q3_r;
  logic [rlfpg_pkg::Y_W+31:0] mul3;
  // stage 4: remainder below twice the modulus
  rlfpg_pkg::code_t code4_r;
  logic             inv4_r, lt4_r;
  rlfpg_pkg::rem_t  r4_r;
  logic [rlfpg_pkg::Q_W+rlfpg_pkg::MOD_W-1:0] qm4;
  rlfpg_pkg::y_t    rfull4;
  rlfpg_pkg::mod_t  m4;
  // stage 5: position within cycle
  rlfpg_pkg::code_t code5_r;
  logic             inv5_r, lt5_r;
  rlfpg_pkg::mod_t  pos5_r, m5;
  // stage 6: percentages
  logic             inv6_r;
  rlfpg_pkg::pct_t  pct6_r [3];
  rlfpg_pkg::pct_t  pr, pg, pb;
  rlfpg_pkg::mod_t  tri6;
  logic [26:0]      tmul6;
  logic             on6;
  // stage 7: scale products
  logic             inv7_r;
  logic [rlfpg_pkg::Q100_W+rlfpg_pkg::PCT_W-1:0] pq7_r [3];
  logic [13:0]      pr7_r [3];
  // stage 8: output register
  logic             st8_r;
  logic [31:0]      pulse8_r [3];
  logic [26:0]      rmul8 [3];
  rlfpg_pkg::per_t  sum8 [3];

  assign en  = !v8_r || out_tready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r} <= '0;
    end else if (en) begin
      v1_r <= !q_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_comb begin
    el_pad = '0;
    el_pad[rlfpg_pkg::TIME_BITS-1:0] = rd_data.el;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code1_r <= rd_data.code;
      inv1_r  <= rd_data.inv;
      lt1_r   <= (rd_data.el < rlfpg_pkg::EL_SHORT);
      for (int i = 0; i < rlfpg_pkg::NB; i++)
        prod1_r[i] <= el_pad[8*i +: 8] * rlfpg_pkg::RES_TAB[rd_data.code][i];
    end
  end

  always_comb begin
    ysum = '0;
    for (int i = 0; i < rlfpg_pkg::NB; i++)
      ysum = ysum + rlfpg_pkg::y_t'(prod1_r[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code2_r <= code1_r;
      inv2_r  <= inv1_r;
      lt2_r   <= lt1_r;
      y2_r    <= ysum;
    end
  end

  assign mul3 = y2_r * rlfpg_pkg::pat_recip(code2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      code3_r <= code2_r;
      inv3_r  <= inv2_r;
      lt3_r   <= lt2_r;
      y3_r    <= y2_r;
      q3_r    <= rlfpg_pkg::q_t'(mul3 >> rlfpg_pkg::RECIP_SHIFT);
    end
  end

  // estimate is at most one short of the true quotient
  assign m4     = rlfpg_pkg::pat_modulus(code3_r);
  assign qm4    = q3_r * m4;
  assign rfull4 = y3_r - rlfpg_pkg::y_t'(qm4);

  always_ff @(posedge clk) begin
    if (en) begin
      code4_r <= code3_r;
      inv4_r  <= inv3_r;
      lt4_r   <= lt3_r;
      r4_r    <= rlfpg_pkg::rem_t'(rfull4);
    end
  end

  assign m5 = rlfpg_pkg::pat_modulus(code4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      code5_r <= code4_r;
      inv5_r  <= inv4_r;
      lt5_r   <= lt4_r;
      if (r4_r >= rlfpg_pkg::rem_t'(m5))
        pos5_r <= rlfpg_pkg::mod_t'(r4_r - rlfpg_pkg::rem_t'(m5));
      else
        pos5_r <= rlfpg_pkg::mod_t'(r4_r);
    end
  end

  always_comb begin
    // triangle ramp: up over the first half, down over the second
    tri6  = (pos5_r <= rlfpg_pkg::mod_t'(1000)) ? pos5_r : rlfpg_pkg::mod_t'(2000) - pos5_r;
    tmul6 = tri6 * rlfpg_pkg::DIV10_MUL;
    pr = rlfpg_pkg::PCT_OFF;
    pg = rlfpg_pkg::PCT_OFF;
    pb = rlfpg_pkg::PCT_OFF;
    on6 = 1'b0;
    unique case (code5_r) inside
      rlfpg_pkg::PAT_PRIV_REC, rlfpg_pkg::PAT_PRIV_UNK: begin
        pr = rlfpg_pkg::PCT_FULL;
      end
      rlfpg_pkg::PAT_VOICE: begin
        pr = rlfpg_pkg::PCT_FULL;
        if (pos5_r < rlfpg_pkg::mod_t'(250)) pb = rlfpg_pkg::PCT_VOICE;
      end
      rlfpg_pkg::PAT_BOOT: begin
        on6 = (pos5_r < rlfpg_pkg::mod_t'(200)) ||
              (pos5_r >= rlfpg_pkg::mod_t'(400) && pos5_r < rlfpg_pkg::mod_t'(600));
        if (on6) pb = rlfpg_pkg::PCT_FULL;
      end
      rlfpg_pkg::PAT_PAIR: begin
        if (pos5_r < rlfpg_pkg::mod_t'(250)) pb = rlfpg_pkg::PCT_FULL;
      end
      rlfpg_pkg::PAT_UPDATE: begin
        pb = rlfpg_pkg::pct_t'(tmul6 >> rlfpg_pkg::DIV10_SHIFT);
      end
      rlfpg_pkg::PAT_VALIDATE: begin
        on6 = (pos5_r < rlfpg_pkg::mod_t'(150)) ||
              (pos5_r >= rlfpg_pkg::mod_t'(300) && pos5_r < rlfpg_pkg::mod_t'(450));
        if (on6) pb = rlfpg_pkg::PCT_FULL;
      end
      rlfpg_pkg::PAT_RECOVERY: begin
        on6 = (pos5_r < rlfpg_pkg::mod_t'(300)) ||
              (pos5_r >= rlfpg_pkg::mod_t'(600) && pos5_r < rlfpg_pkg::mod_t'(900));
        if (on6) begin
          pr = rlfpg_pkg::PCT_FULL;
          pg = rlfpg_pkg::PCT_AMBER;
        end
      end
      rlfpg_pkg::PAT_FAULT: begin
        on6 = (pos5_r < rlfpg_pkg::mod_t'(150)) ||
              (pos5_r >= rlfpg_pkg::mod_t'(300) && pos5_r < rlfpg_pkg::mod_t'(450)) ||
              (pos5_r >= rlfpg_pkg::mod_t'(600) && pos5_r < rlfpg_pkg::mod_t'(750));
        if (on6) begin
          pr = rlfpg_pkg::PCT_FULL;
          pg = rlfpg_pkg::PCT_AMBER;
        end
      end
      rlfpg_pkg::PAT_CHARGE: begin
        if (pos5_r < rlfpg_pkg::mod_t'(200)) pg = rlfpg_pkg::PCT_FULL;
      end
      rlfpg_pkg::PAT_LOWPOW: begin
        if (pos5_r < rlfpg_pkg::mod_t'(200)) begin
          pr = rlfpg_pkg::PCT_FULL;
          pg = rlfpg_pkg::PCT_AMBER;
        end
      end
      rlfpg_pkg::PAT_READY: begin
        if (lt5_r) pb = rlfpg_pkg::PCT_FULL;
      end
      rlfpg_pkg::PAT_DISCONN: begin
        if (lt5_r) begin
          pr = rlfpg_pkg::PCT_FULL;
          pg = rlfpg_pkg::PCT_AMBER;
        end
      end
      default: ;
    endcase
    // invalid code gives zero pulses
    if (inv5_r) begin
      pr = rlfpg_pkg::PCT_OFF;
      pg = rlfpg_pkg::PCT_OFF;
      pb = rlfpg_pkg::PCT_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv6_r    <= inv5_r;
      pct6_r[0] <= pr;
      pct6_r[1] <= pg;
      pct6_r[2] <= pb;
    end
  end

  // period * p / 100 = (period / 100) * p + ((period % 100) * p) / 100
  always_ff @(posedge clk) begin
    if (en) begin
      inv7_r <= inv6_r;
      for (int c = 0; c < 3; c++) begin
        pq7_r[c] <= scale[c].q * pct6_r[c];
        pr7_r[c] <= scale[c].r * pct6_r[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rmul8[c] = pr7_r[c] * rlfpg_pkg::DIV100_MUL;
      sum8[c]  = rlfpg_pkg::per_t'(pq7_r[c]) +
                 rlfpg_pkg::per_t'(rmul8[c] >> rlfpg_pkg::DIV100_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st8_r <= inv7_r ? rlfpg_pkg::ST_BAD : rlfpg_pkg::ST_OK;
      for (int c = 0; c < 3; c++)
        pulse8_r[c] <= 32'(sum8[c]);
    end
  end

  assign out_tvalid = v8_r;
  assign out_tuser  = st8_r;
  assign out_tdata  = {pulse8_r[2], pulse8_r[1], pulse8_r[0]};

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v8_r && (out_tuser == rlfpg_pkg::ST_BAD) |-> out_tdata == '0)
    else $error("invalid code result carries nonzero pulses");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> rfull4 < rlfpg_pkg::y_t'({m4, 1'b0}))
    else $error("quotient estimate off by more than one");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> pos5_r < rlfpg_pkg::pat_modulus(code5_r))
    else $error("cycle position not below modulus");

endmodule

`default_nettype wire

// ===== test/tb_rgb_led_feedback_pattern_generator_top.sv =====
// testbench for the rgb led feedback pattern generator: directed and random update
// transactions, with random sender gaps, receiver stalls and one long output hold-off.
// depends on rlfpg_pkg and rgb_led_feedback_pattern_generator_top
`timescale 1ns / 100ps

module tb_rgb_led_feedback_pattern_generator_top;

  localparam int RUN_LIMIT    = 400000;
  localparam int ITEMS_PER_PH = 200;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 12;

  // tracks pattern state and PWM periods, predicts the pulse widths of each update
  class pulse_scoreboard;
    typedef struct {
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      logic        status;
    } pulse_t;

    logic [31:0]      period [3];
    rlfpg_pkg::code_t cur_pat;
    rlfpg_pkg::ms_t   start_ms;
    pulse_t           expected_pulses [$];
    int               errors;
    int               updates;
    int               checked;
    bit               code_seen [16];

    function new();
      period   = '{32'd0, 32'd0, 32'd0};
      cur_pat  = rlfpg_pkg::PAT_NONE;
      start_ms = '0;
      errors   = 0;
      updates  = 0;
      checked  = 0;
      foreach (code_seen[i]) code_seen[i] = 1'b0;
    endfunction

    function void set_period(logic [1:0] idx, logic [31:0] val);
      case (idx)
        rlfpg_pkg::CFG_RED:   period[0] = val;
        rlfpg_pkg::CFG_GREEN: period[1] = val;
        rlfpg_pkg::CFG_BLUE:  period[2] = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pulses.size();
    endfunction

    function int codes_covered();
      int n;
      n = 0;
      foreach (code_seen[i]) n += code_seen[i];
      return n;
    endfunction

    // percentages of each pattern as a function of elapsed time
    function void pattern_pct(rlfpg_pkg::code_t c, rlfpg_pkg::ms_t el,
                              output rlfpg_pkg::pct_t r, output rlfpg_pkg::pct_t g,
                              output rlfpg_pkg::pct_t b);
      rlfpg_pkg::ms_t pos;
      logic           on;
      r  = rlfpg_pkg::PCT_OFF;
      g  = rlfpg_pkg::PCT_OFF;
      b  = rlfpg_pkg::PCT_OFF;
      on = 1'b0;
      case (c)
        rlfpg_pkg::PAT_PRIV_REC, rlfpg_pkg::PAT_PRIV_UNK: r = rlfpg_pkg::PCT_FULL;
        rlfpg_pkg::PAT_VOICE: begin
          r = rlfpg_pkg::PCT_FULL;
          if (el % 500 < 250) b = rlfpg_pkg::PCT_VOICE;
        end
        rlfpg_pkg::PAT_BOOT: begin
          pos = el % 2400;
          if (pos < 200 || (pos >= 400 && pos < 600)) b = rlfpg_pkg::PCT_FULL;
        end
        rlfpg_pkg::PAT_PAIR: begin
          if (el % 500 < 250) b = rlfpg_pkg::PCT_FULL;
        end
        rlfpg_pkg::PAT_UPDATE: begin
          pos = el % 2000;
          b = rlfpg_pkg::pct_t'(((pos <= 1000) ? pos : 2000 - pos) / 10);
        end
        rlfpg_pkg::PAT_VALIDATE: begin
          pos = el % 1800;
          if (pos < 150 || (pos >= 300 && pos < 450)) b = rlfpg_pkg::PCT_FULL;
        end
        rlfpg_pkg::PAT_RECOVERY: begin
          pos = el % 3000;
          on = pos < 300 || (pos >= 600 && pos < 900);
        end
        rlfpg_pkg::PAT_FAULT: begin
          pos = el % 2450;
          on = pos < 150 || (pos >= 300 && pos < 450) || (pos >= 600 && pos < 750);
        end
        rlfpg_pkg::PAT_CHARGE: begin
          if (el % 4000 < 200) g = rlfpg_pkg::PCT_FULL;
        end
        rlfpg_pkg::PAT_LOWPOW:  on = el % 10000 < 200;
        rlfpg_pkg::PAT_READY: begin
          if (el < 300) b = rlfpg_pkg::PCT_FULL;
        end
        rlfpg_pkg::PAT_DISCONN: on = el < 300;
        default: ;
      endcase
      // amber patterns drive red full and green partly
      if (on) begin
        r = rlfpg_pkg::PCT_FULL;
        g = rlfpg_pkg::PCT_AMBER;
      end
    endfunction

    function logic [31:0] scaled(logic [31:0] per, rlfpg_pkg::pct_t pct);
      logic [63:0] prod;
      prod = 64'(per) * 64'(pct);
      return 32'(prod / 64'd100);
    endfunction

    function void note_update(rlfpg_pkg::code_t code, rlfpg_pkg::ms_t now);
      pulse_t          e;
      rlfpg_pkg::ms_t  el;
      rlfpg_pkg::pct_t r, g, b;
      updates++;
      code_seen[code] = 1'b1;
      if (code >= rlfpg_pkg::PAT_COUNT) begin
        e = '{32'd0, 32'd0, 32'd0, rlfpg_pkg::ST_BAD};
      end else begin
        if (code != cur_pat) begin
          cur_pat  = code;
          start_ms = now;
        end
        el = (now >= start_ms) ? now - start_ms : '0;
        pattern_pct(code, el, r, g, b);
        e = '{scaled(period[0], r), scaled(period[1], g), scaled(period[2], b),
              rlfpg_pkg::ST_OK};
      end
      expected_pulses.push_back(e);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 100)
        $display("mismatch on %s at result %0d: got %0h, want %0h", field, checked, got, want);
    endtask

    task check_pulses(logic [rlfpg_pkg::OUT_W-1:0] data, logic status);
      pulse_t e;
      if (expected_pulses.size() == 0) begin
        report("unexpected result", data[31:0], 32'd0);
      end else begin
        e = expected_pulses.pop_front();
        if (data[31:0] !== e.red)    report("red_pulse", data[31:0], e.red);
        if (data[63:32] !== e.green) report("green_pulse", data[63:32], e.green);
        if (data[95:64] !== e.blue)  report("blue_pulse", data[95:64], e.blue);
        if (status !== e.status)     report("status", 32'(status), 32'(e.status));
      end
      checked++;
    endtask
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [rlfpg_pkg::IN_W-1:0]     in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [rlfpg_pkg::OUT_W-1:0]    out_tdata;
  logic                           out_tuser;
  logic                           cfg_we     = 1'b0;
  logic [1:0]                     cfg_index  = rlfpg_pkg::CFG_RED;
  logic [31:0]                    cfg_wdata  = '0;

  pulse_scoreboard sb = new();

  int               cycle_count = 0;
  int               burst_left  = 0;
  bit               hold_req    = 1'b0;
  bit               hold_done   = 1'b0;
  rlfpg_pkg::code_t walk_code   = rlfpg_pkg::PAT_BOOT;
  rlfpg_pkg::ms_t   walk_ms     = '0;

  rgb_led_feedback_pattern_generator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("run exceeded %0d cycles with %0d results pending", RUN_LIMIT, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // transaction monitors, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_update(in_tdata[rlfpg_pkg::CODE_W-1:0],
                     in_tdata[rlfpg_pkg::CODE_W +: rlfpg_pkg::TIME_BITS]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_pulses(out_tdata, out_tuser);
  end

  // receiver: segments of always-ready, random and periodic stalls, plus the long hold
  initial begin
    int mode;
    int len;
    int duty;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 80);
        duty = $urandom_range(2, 6);
        for (int k = 0; k < len; k++) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= (k % duty) != 0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_update(rlfpg_pkg::code_t code, rlfpg_pkg::ms_t now);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(rlfpg_pkg::IN_W - rlfpg_pkg::CODE_W - rlfpg_pkg::TIME_BITS){1'b0}},
                  now, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // let everything in flight come out before touching the registers
  task automatic wait_idle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    // step past the edge so the monitor has noted the last accepted transaction
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_period(idx, val);
  endtask

  task automatic set_periods(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    cfg_write(rlfpg_pkg::CFG_RED, r);
    cfg_write(rlfpg_pkg::CFG_GREEN, g);
    cfg_write(rlfpg_pkg::CFG_BLUE, b);
    cfg_we <= 1'b0;
  endtask

  function automatic rlfpg_pkg::ms_t random_ms();
    return rlfpg_pkg::ms_t'({$urandom(), $urandom()});
  endfunction

  // mostly a running pattern with advancing time, some switches, noise and time reversal
  task automatic run_random(int count);
    int             pick;
    rlfpg_pkg::ms_t now;
    rlfpg_pkg::ms_t back;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        walk_code = rlfpg_pkg::code_t'($urandom_range(0, 13));
        walk_ms   = walk_ms + rlfpg_pkg::ms_t'($urandom_range(0, 300));
        now       = walk_ms;
      end else if (pick < 12) begin
        send_update(rlfpg_pkg::code_t'($urandom_range(14, 15)), random_ms());
        continue;
      end else if (pick < 16) begin
        back = rlfpg_pkg::ms_t'($urandom_range(1, 1000));
        now  = (walk_ms > back) ? walk_ms - back : '0;
      end else if (pick < 20) begin
        now = random_ms();
      end else if (pick < 23) begin
        walk_code = rlfpg_pkg::code_t'($urandom_range(0, 13));
        walk_ms   = random_ms();
        now       = walk_ms;
      end else begin
        if ($urandom_range(0, 3) == 0)
          walk_ms = walk_ms + rlfpg_pkg::ms_t'($urandom_range(0, 5000));
        else
          walk_ms = walk_ms + rlfpg_pkg::ms_t'($urandom_range(0, 300));
        now = walk_ms;
      end
      send_update(walk_code, now);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero periods straight after reset: every pulse must be zero
    send_update(rlfpg_pkg::PAT_PRIV_REC, rlfpg_pkg::ms_t'(0));
    send_update(rlfpg_pkg::PAT_VOICE, rlfpg_pkg::ms_t'(10));
    send_update(rlfpg_pkg::PAT_CHARGE, rlfpg_pkg::ms_t'(20));
    wait_idle();
    set_periods(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom());

    // one transaction of every code, including both invalid ones
    for (int c = 0; c < 16; c++)
      send_update(rlfpg_pkg::code_t'(c), rlfpg_pkg::ms_t'(100000 + c * 7));

    // window edges, time going backwards, invalid code leaving state alone
    send_update(rlfpg_pkg::PAT_VOICE, rlfpg_pkg::ms_t'(1000));
    send_update(rlfpg_pkg::PAT_VOICE, rlfpg_pkg::ms_t'(1249));
    send_update(rlfpg_pkg::PAT_VOICE, rlfpg_pkg::ms_t'(1250));
    send_update(rlfpg_pkg::PAT_VOICE, rlfpg_pkg::ms_t'(900));
    send_update(rlfpg_pkg::PAT_UPDATE, rlfpg_pkg::ms_t'(5000));
    send_update(rlfpg_pkg::PAT_UPDATE, rlfpg_pkg::ms_t'(6000));
    send_update(rlfpg_pkg::code_t'(rlfpg_pkg::PAT_COUNT + 1), '1);
    send_update(rlfpg_pkg::PAT_UPDATE, rlfpg_pkg::ms_t'(6999));
    send_update(rlfpg_pkg::PAT_LOWPOW, '1);
    send_update(rlfpg_pkg::PAT_LOWPOW, '1);

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0:       set_periods(32'hFFFF_FFFF, 32'd0, 32'd1);
        1:       set_periods($urandom(), $urandom(), $urandom());
        2:       set_periods(32'd100, 32'd99, 32'h8000_0000);
        3:       set_periods(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_periods($urandom_range(0, 255), $urandom(), 32'd0);
      endcase
      if (ph == 2) hold_req = 1'b1;
      run_random(ITEMS_PER_PH);
    end
    wait_idle();

    $display("sent %0d updates over %0d of 16 codes, checked %0d results",
             sb.updates, sb.codes_covered(), sb.checked);
    $display("seven period settings incl. zero and full-scale, long output hold %s",
             hold_done ? "seen" : "missed");
    if (sb.pending() != 0)
      sb.report("results never arrived", 32'(sb.pending()), 32'd0);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
